>>> sv/psh_pkg.sv
`default_nettype none
package psh_pkg;

   // widest bin address the store supports (BIN_COUNT up to 4096)
   localparam int unsigned AddrMaxW = 12;
   // bin_index code for a dropped particle
   localparam logic [8:0] DropCode = 9'd256;
   localparam logic [31:0] SpeedLimitReset = 32'd65536;
   localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

   // request command codes
   localparam logic CmdAdd  = 1'b0;
   localparam logic CmdRead = 1'b1;

   // one classified request, passed from front to back
   typedef struct packed {
      logic                is_read;
      logic                in_range;
      logic [AddrMaxW-1:0] addr;
      logic [8:0]          idx;
      logic                positive;
      logic                eop;
   } item_type;

   // queue handshake between producer and consumer
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_sts_type;

endpackage
`default_nettype wire

>>> sv/particle_speed_histogram_core.sv
`default_nettype none
// Particle speed histogram core.
// Request channel: start/busy. A request is taken at a clock edge with start
// high and busy low. req_cmd selects add (velocity binned into the positive or
// non-positive store) or read (both counts of req_read_bin returned).
// Response channel: rsp_valid strobes for one cycle with the result fields;
// the receiver cannot stall it.
// Config channel: csr_valid/csr_ready writes speed_limit; always ready.
// Steps: an add runs squaring, a bitwise square root, a multiply, a restoring
// divide and a push, then the back end's pop and update; a read runs only
// the push and the back end.
// The front holds one request at a time and takes no new one until it has
// pushed the last; the two-entry queue lets the back finish while the front
// works on the next request.
// Reset: after reset a clearing pass zeroes both count stores, one bin per
// cycle; busy stays high meanwhile. speed_limit resets to 1.0.
module particle_speed_histogram_core #(
   parameter int unsigned BIN_COUNT = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_cmd,
   input  wire logic signed [31:0] req_vel_x,
   input  wire logic signed [31:0] req_vel_y,
   input  wire logic signed [31:0] req_vel_z,
   input  wire logic              req_positive_charge,
   input  wire logic [7:0]        req_read_bin,
   input  wire logic              req_end_of_pass,
   output logic                   rsp_valid,
   output logic [8:0]             rsp_bin_index,
   output logic                   rsp_counted,
   output logic [31:0]            rsp_positive_count,
   output logic [31:0]            rsp_negative_count,
   output logic                   rsp_pass_done,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_speed_limit
);

   logic [31:0] speed_limit_ff, speed_limit_in;
   logic front_busy, clearing, q_push, q_pop;
   psh_pkg::item_type push_item, pop_item;
   psh_pkg::queue_ctl_type q_ctl;
   psh_pkg::queue_sts_type q_sts;

   assign csr_ready = 1'b1;
   assign busy = front_busy | clearing;
   assign q_ctl.push = q_push;
   assign q_ctl.pop = q_pop;

   // speed limit register
   assign speed_limit_in = (csr_valid && csr_ready) ? csr_speed_limit : speed_limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= psh_pkg::SpeedLimitReset;
      end else begin
         speed_limit_ff <= speed_limit_in;
      end
   end

   psh_front #(.BIN_COUNT(BIN_COUNT)) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .front_busy      (front_busy),
      .cmd             (req_cmd),
      .vel_x           (req_vel_x),
      .vel_y           (req_vel_y),
      .vel_z           (req_vel_z),
      .positive_charge (req_positive_charge),
      .read_bin        (req_read_bin),
      .end_of_pass     (req_end_of_pass),
      .block_busy      (busy),
      .speed_limit     (speed_limit_ff),
      .q_sts           (q_sts),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   psh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (q_ctl),
      .wr_item (push_item),
      .rd_item (pop_item),
      .sts     (q_sts)
   );

   psh_back #(.BIN_COUNT(BIN_COUNT)) u_back (
      .clock              (clock),
      .reset              (reset),
      .clearing           (clearing),
      .q_sts              (q_sts),
      .q_item             (pop_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_bin_index      (rsp_bin_index),
      .rsp_counted        (rsp_counted),
      .rsp_positive_count (rsp_positive_count),
      .rsp_negative_count (rsp_negative_count),
      .rsp_pass_done      (rsp_pass_done)
   );

   // back end never gives back-to-back responses
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   // an accepted request holds the request channel off
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // a counted add names a bin inside the store (checked up to 256 bins; bins above 511 wrap to 9 bits)
   a_counted_bin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_counted && (BIN_COUNT <= 256))
         |-> (rsp_bin_index != psh_pkg::DropCode))
      else $error("counted response with drop code");

   // no responses during the clearing pass
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid)
      else $error("response while clearing");

endmodule
`default_nettype wire

>>> sv/psh_front.sv
`default_nettype none
module psh_front #(
   parameter int unsigned BIN_COUNT = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   front_busy,
   input  wire logic              cmd,
   input  wire logic signed [31:0] vel_x,
   input  wire logic signed [31:0] vel_y,
   input  wire logic signed [31:0] vel_z,
   input  wire logic              positive_charge,
   input  wire logic [7:0]        read_bin,
   input  wire logic              end_of_pass,
   input  wire logic              block_busy,
   input  wire logic [31:0]       speed_limit,
   input  wire psh_pkg::queue_sts_type q_sts,
   output logic                   q_push,
   output psh_pkg::item_type      q_item
);

   localparam int unsigned BcW = $clog2(BIN_COUNT + 1);
   localparam int unsigned NumW = 32 + BcW + 1;
   localparam int unsigned DivCntW = $clog2(NumW + 1);

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_SQ   = 6'b000010,
      F_SQRT = 6'b000100,
      F_MUL  = 6'b001000,
      F_DIV  = 6'b010000,
      F_PUSH = 6'b100000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [31:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [1:0] sq_cnt_ff, sq_cnt_in;
   logic [63:0] sq_ff, sq_in, acc_ff, acc_in;
   logic [63:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [NumW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [DivCntW-1:0] div_cnt_ff, div_cnt_in;
   psh_pkg::item_type item_ff, item_in;

   logic [31:0] comp, mag, lim;
   logic [63:0] trial;
   logic [32:0] shifted;

   assign front_busy = (state_ff != F_IDLE);
   assign q_push = (state_ff == F_PUSH) && !q_sts.full;
   assign q_item = item_ff;
   assign lim = (speed_limit == 32'd0) ? 32'd1 : speed_limit;

   // component magnitude feeding the squarer
   always_comb begin
      unique case (sq_cnt_ff)
         2'd0:    comp = vx_ff;
         2'd1:    comp = vy_ff;
         default: comp = vz_ff;
      endcase
      mag = comp[31] ? (~comp + 32'd1) : comp;
      trial = res_ff + bit_ff;
      shifted = {rem_ff, num_ff[NumW-1]};
   end

   // sequencer and datapath
   always_comb begin
      state_in = state_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      vz_in = vz_ff;
      sq_cnt_in = sq_cnt_ff;
      sq_in = sq_ff;
      acc_in = acc_ff;
      x_in = x_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_cnt_in = div_cnt_ff;
      item_in = item_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start && !block_busy) begin
               vx_in = vel_x;
               vy_in = vel_y;
               vz_in = vel_z;
               item_in.positive = positive_charge;
               item_in.eop = end_of_pass;
               item_in.is_read = (cmd == psh_pkg::CmdRead);
               if (cmd == psh_pkg::CmdRead) begin
                  item_in.in_range = (13'(read_bin) < 13'(BIN_COUNT));
                  item_in.addr = psh_pkg::AddrMaxW'(read_bin);
                  item_in.idx = {1'b0, read_bin};
                  state_in = F_PUSH;
               end else begin
                  sq_cnt_in = 2'd0;
                  acc_in = 64'd0;
                  state_in = F_SQ;
               end
            end
         end
         F_SQ: begin
            // one square per cycle, accumulated in the following cycle
            sq_in = 64'(mag) * 64'(mag);
            if (sq_cnt_ff != 2'd0) begin
               acc_in = acc_ff + sq_ff;
            end
            sq_cnt_in = sq_cnt_ff + 2'd1;
            if (sq_cnt_ff == 2'd3) begin
               x_in = acc_ff + sq_ff;
               res_in = 64'd0;
               bit_in = 64'd1 << 62;
               state_in = F_SQRT;
            end
         end
         F_SQRT: begin
            // one root bit per cycle
            if (x_ff >= trial) begin
               x_in = x_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            num_in = NumW'(res_ff[31:0]) * NumW'(BIN_COUNT) + NumW'(lim) - NumW'(1);
            rem_in = 32'd0;
            quo_in = '0;
            div_cnt_in = '0;
            state_in = F_DIV;
         end
         F_DIV: begin
            // restoring division, one quotient bit per cycle
            num_in = num_ff << 1;
            if (shifted >= {1'b0, lim}) begin
               rem_in = 32'(shifted - {1'b0, lim});
               quo_in = {quo_ff[NumW-2:0], 1'b1};
            end else begin
               rem_in = shifted[31:0];
               quo_in = {quo_ff[NumW-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DivCntW'(1);
            if (div_cnt_ff == DivCntW'(NumW - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            // wait for queue room; the item was filled in at accept (read) or when the quotient completed (add)
            if (!item_ff.is_read && !(state_ff != F_PUSH)) begin
               item_in = item_ff;
            end
            if (!q_sts.full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
      // capture the bin when the quotient completes
      if (state_ff == F_DIV && state_in == F_PUSH) begin
         item_in.in_range = (quo_in < NumW'(BIN_COUNT));
         item_in.addr = quo_in[psh_pkg::AddrMaxW-1:0];
         item_in.idx = (quo_in < NumW'(BIN_COUNT)) ? quo_in[8:0] : psh_pkg::DropCode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      vz_ff <= vz_in;
      sq_cnt_ff <= sq_cnt_in;
      sq_ff <= sq_in;
      acc_ff <= acc_in;
      x_ff <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_cnt_ff <= div_cnt_in;
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

>>> sv/psh_queue.sv
`default_nettype none
module psh_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire psh_pkg::queue_ctl_type ctl,
   input  wire psh_pkg::item_type      wr_item,
   output psh_pkg::item_type           rd_item,
   output psh_pkg::queue_sts_type      sts
);

   // two-entry queue
   psh_pkg::item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign sts.full = (cnt_ff == 2'd2);
   assign sts.empty = (cnt_ff == 2'd0);
   assign do_push = ctl.push && !sts.full;
   assign do_pop = ctl.pop && !sts.empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule
`default_nettype wire

>>> sv/psh_back.sv
`default_nettype none
module psh_back #(
   parameter int unsigned BIN_COUNT = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   output logic                       clearing,
   input  wire psh_pkg::queue_sts_type q_sts,
   input  wire psh_pkg::item_type     q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   output logic [8:0]                 rsp_bin_index,
   output logic                       rsp_counted,
   output logic [31:0]                rsp_positive_count,
   output logic [31:0]                rsp_negative_count,
   output logic                       rsp_pass_done
);

   localparam int unsigned AddrW = $clog2(BIN_COUNT);

   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_UPD   = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [AddrW-1:0] clr_ff, clr_in;
   psh_pkg::item_type cur_ff, cur_in;
   logic [31:0] pos_mem [BIN_COUNT];
   logic [31:0] neg_mem [BIN_COUNT];
   logic [31:0] pos_rd_ff, neg_rd_ff;
   logic valid_ff, valid_in;
   logic [8:0] idx_ff, idx_in;
   logic counted_ff, counted_in, eop_ff, eop_in;
   logic [31:0] pcnt_ff, pcnt_in, ncnt_ff, ncnt_in;
   logic pos_we, neg_we;
   logic [AddrW-1:0] wr_addr;
   logic [31:0] pos_wd, neg_wd, pos_new, neg_new;

   assign clearing = (state_ff == B_CLEAR);
   assign q_pop = (state_ff == B_IDLE) && !q_sts.empty;
   assign rsp_valid = valid_ff;
   assign rsp_bin_index = idx_ff;
   assign rsp_counted = counted_ff;
   assign rsp_positive_count = pcnt_ff;
   assign rsp_negative_count = ncnt_ff;
   assign rsp_pass_done = eop_ff;

   // saturating increments of the fetched counts
   assign pos_new = (pos_rd_ff == psh_pkg::CountMax) ? pos_rd_ff : pos_rd_ff + 32'd1;
   assign neg_new = (neg_rd_ff == psh_pkg::CountMax) ? neg_rd_ff : neg_rd_ff + 32'd1;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cur_in = cur_ff;
      valid_in = 1'b0;
      idx_in = idx_ff;
      counted_in = 1'b0;
      eop_in = eop_ff;
      pcnt_in = pcnt_ff;
      ncnt_in = ncnt_ff;
      pos_we = 1'b0;
      neg_we = 1'b0;
      wr_addr = cur_ff.addr[AddrW-1:0];
      pos_wd = pos_new;
      neg_wd = neg_new;
      unique case (state_ff)
         B_CLEAR: begin
            // zero one bin of both stores per cycle
            pos_we = 1'b1;
            neg_we = 1'b1;
            wr_addr = clr_ff;
            pos_wd = 32'd0;
            neg_wd = 32'd0;
            clr_in = clr_ff + AddrW'(1);
            if (clr_ff == AddrW'(BIN_COUNT - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_sts.empty) begin
               cur_in = q_item;
               state_in = B_UPD;
            end
         end
         B_UPD: begin
            valid_in = 1'b1;
            idx_in = cur_ff.idx;
            eop_in = cur_ff.eop;
            pcnt_in = 32'd0;
            ncnt_in = 32'd0;
            if (cur_ff.is_read) begin
               if (cur_ff.in_range) begin
                  pcnt_in = pos_rd_ff;
                  ncnt_in = neg_rd_ff;
               end
            end else if (cur_ff.in_range) begin
               counted_in = 1'b1;
               pos_we = cur_ff.positive;
               neg_we = !cur_ff.positive;
               pcnt_in = cur_ff.positive ? pos_new : pos_rd_ff;
               ncnt_in = cur_ff.positive ? neg_rd_ff : neg_new;
            end
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // count stores: one write, one registered read
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[wr_addr] <= pos_wd;
      end
      if (neg_we) begin
         neg_mem[wr_addr] <= neg_wd;
      end
      pos_rd_ff <= pos_mem[q_item.addr[AddrW-1:0]];
      neg_rd_ff <= neg_mem[q_item.addr[AddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         valid_ff <= valid_in;
      end
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      counted_ff <= counted_in;
      eop_ff <= eop_in;
      pcnt_ff <= pcnt_in;
      ncnt_ff <= ncnt_in;
   end

endmodule
`default_nettype wire
